FILE: rtl/ckpb_pkg.sv
// ckpb_pkg: shared types and constants of the color keyed palette blitter
// configuration word layout, register indexes and queue entry format
// no dependencies
package ckpb_pkg;

  localparam int ADDR_BITS       = 24;
  localparam int PALETTE_ENTRIES = 16;
  localparam int PIXEL_W         = 8;
  localparam int COLOR_W         = 8;
  localparam int NIBBLE_W        = $clog2(PALETTE_ENTRIES);
  localparam int DIM_W           = 16;
  localparam int BASE_W          = 24;
  localparam int PAL_WORD_W      = 64;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [DIM_W-1:0]     dim_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_COLOR    = 3'd0,
    REG_PALETTE_LOW  = 3'd1,
    REG_PALETTE_HIGH = 3'd2,
    REG_AREA_WIDTH   = 3'd3,
    REG_AREA_HEIGHT  = 3'd4,
    REG_DEST_BASE    = 3'd5,
    REG_DEST_STRIDE  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PIXEL_W-1:0]    key_color;
    logic [PAL_WORD_W-1:0] palette_low;
    logic [PAL_WORD_W-1:0] palette_high;
    dim_t                  area_width;
    dim_t                  area_height;
    logic [BASE_W-1:0]     dest_base;
    dim_t                  dest_stride;
  } ckpb_cfg_t;

  typedef struct packed {
    logic                keyed;
    logic [NIBBLE_W-1:0] nibble;
    addr_t               address;
    logic                last;
  } ckpb_entry_t;

endpackage

FILE: rtl/ckpb_if.sv
// ckpb_pix_if, ckpb_wr_if: valid/ready channels of the blitter
// pixel word in, destination write word out
// depends on ckpb_pkg
interface ckpb_pix_if;
  import ckpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink (input valid, input source_pixel, output ready);
endinterface

interface ckpb_wr_if;
  import ckpb_pkg::*;
  logic               valid;
  logic               ready;
  logic               write_enable;
  addr_t              dest_address;
  logic [COLOR_W-1:0] write_data;
  logic               last;

  modport source (output valid, output write_enable, output dest_address,
                  output write_data, output last, input ready);
  modport sink (input valid, input write_enable, input dest_address,
                input write_data, input last, output ready);
endinterface

FILE: rtl/ckpb_cfg.sv
// ckpb_cfg: configuration register file of the blitter
// depends on ckpb_pkg
module ckpb_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ckpb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ckpb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ckpb_pkg::ckpb_cfg_t                 cfg_o
);
  import ckpb_pkg::*;

  ckpb_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_COLOR:    cfg_d.key_color    = cfg_data_i[PIXEL_W-1:0];
        REG_PALETTE_LOW:  cfg_d.palette_low  = cfg_data_i[PAL_WORD_W-1:0];
        REG_PALETTE_HIGH: cfg_d.palette_high = cfg_data_i[PAL_WORD_W-1:0];
        REG_AREA_WIDTH:   cfg_d.area_width   = cfg_data_i[DIM_W-1:0];
        REG_AREA_HEIGHT:  cfg_d.area_height  = cfg_data_i[DIM_W-1:0];
        REG_DEST_BASE:    cfg_d.dest_base    = cfg_data_i[BASE_W-1:0];
        REG_DEST_STRIDE:  cfg_d.dest_stride  = cfg_data_i[DIM_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_color    <= '0;
      cfg_q.palette_low  <= '0;
      cfg_q.palette_high <= '0;
      cfg_q.area_width   <= dim_t'(1);
      cfg_q.area_height  <= dim_t'(1);
      cfg_q.dest_base    <= '0;
      cfg_q.dest_stride  <= dim_t'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ckpb_front.sv
// ckpb_front: accepts pixel words, tracks row and column, forms the address
// and key decision, and pushes one entry per word into the queue
// depends on ckpb_pkg, ckpb_if
module ckpb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ckpb_pkg::ckpb_cfg_t  cfg_i,
  ckpb_pix_if.sink             pix_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output ckpb_pkg::ckpb_entry_t entry_o
);
  import ckpb_pkg::*;

  dim_t  col_d, col_q;
  dim_t  row_d, row_q;
  addr_t row_start_d, row_start_q;

  addr_t row_start;
  addr_t base;
  dim_t  last_col, last_row;
  logic  row_end, rect_end;

  assign base      = addr_t'(cfg_i.dest_base);
  assign last_col  = cfg_i.area_width - dim_t'(1);
  assign last_row  = cfg_i.area_height - dim_t'(1);
  assign row_start = (col_q == '0 && row_q == '0) ? base : row_start_q;
  assign row_end   = col_q >= last_col;
  assign rect_end  = row_end && (row_q >= last_row);

  assign pix_i.ready = !q_full_i;
  assign push_o      = pix_i.valid && !q_full_i;

  always_comb begin
    entry_o.keyed   = pix_i.source_pixel == cfg_i.key_color;
    entry_o.nibble  = pix_i.source_pixel[NIBBLE_W-1:0];
    entry_o.address = row_start + addr_t'(col_q);
    entry_o.last    = rect_end;
  end

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    row_start_d = row_start_q;
    if (push_o) begin
      if (!row_end) begin
        col_d       = col_q + dim_t'(1);
        row_start_d = row_start;
      end else begin
        col_d = '0;
        if (rect_end) begin
          row_d       = '0;
          row_start_d = base;
        end else begin
          row_d       = row_q + dim_t'(1);
          row_start_d = row_start + addr_t'(cfg_i.dest_stride);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      row_start_q <= '0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      row_start_q <= row_start_d;
    end
  end

endmodule

FILE: rtl/ckpb_queue.sv
// ckpb_queue: short entry queue between front and back
// depends on ckpb_pkg
module ckpb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ckpb_pkg::ckpb_entry_t entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  logic                  pop_i,
  output ckpb_pkg::ckpb_entry_t entry_o
);
  import ckpb_pkg::*;

  ckpb_entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]        wr_ptr_d, wr_ptr_q;
  logic [QPTR_W-1:0]        rd_ptr_d, rd_ptr_q;
  logic [QCNT_W-1:0]        cnt_d, cnt_q;
  logic                     do_push, do_pop;

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: rtl/ckpb_back.sv
// ckpb_back: palette lookup and output register of the destination write word
// depends on ckpb_pkg, ckpb_if
module ckpb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckpb_pkg::ckpb_cfg_t   cfg_i,
  input  logic                  q_valid_i,
  input  ckpb_pkg::ckpb_entry_t entry_i,
  output logic                  pop_o,
  ckpb_wr_if.source             wr_o
);
  import ckpb_pkg::*;

  logic               valid_d, valid_q;
  logic               we_q;
  addr_t              addr_q;
  logic [COLOR_W-1:0] data_q;
  logic               last_q;

  logic [PAL_WORD_W-1:0] pal_word;
  logic [COLOR_W-1:0]    color;

  assign pal_word = entry_i.nibble[NIBBLE_W-1] ? cfg_i.palette_high : cfg_i.palette_low;
  assign color    = pal_word[{entry_i.nibble[NIBBLE_W-2:0], 3'b000} +: COLOR_W];

  assign pop_o = q_valid_i && (!valid_q || wr_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (wr_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      we_q   <= !entry_i.keyed;
      addr_q <= entry_i.address;
      data_q <= entry_i.keyed ? '0 : color;
      last_q <= entry_i.last;
    end
  end

  assign wr_o.valid        = valid_q;
  assign wr_o.write_enable = we_q;
  assign wr_o.dest_address = addr_q;
  assign wr_o.write_data   = data_q;
  assign wr_o.last         = last_q;

endmodule

FILE: rtl/color_keyed_palette_blit.sv
// color_keyed_palette_blit: top level of the color keyed palette blitter
// depends on ckpb_pkg, ckpb_if, ckpb_cfg, ckpb_front, ckpb_queue, ckpb_back
//
// Takes one source pixel word per cycle and gives one destination write word
// per cycle, in order, when the output is not stalled: the front writes each
// accepted word into the two-entry queue and the palette lookup loads the
// queue head into the output register once that is free. The input stays
// ready while the queue has room, so a stalled output holds up to three words
// before the input stalls. Not enforced by the block: configuration must be
// written through cfg_we_i/cfg_idx_i/cfg_data_i only while no rectangle words
// are in flight; row and column counters restart after the word flagged last.
module color_keyed_palette_blit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ckpb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ckpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ckpb_pix_if.sink                        pix_i,
  ckpb_wr_if.source                       wr_o
);
  import ckpb_pkg::*;

  ckpb_cfg_t   cfg;
  ckpb_entry_t push_entry;
  ckpb_entry_t head_entry;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;

  ckpb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ckpb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pix_i    (pix_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  ckpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  ckpb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .entry_i   (head_entry),
    .pop_o     (pop),
    .wr_o      (wr_o)
  );

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench of color_keyed_palette_blit
// streams source pixel words, writes the registers between phases and checks each
// destination write word against a model of the blitter; depends on ckpb_pkg and ckpb_if
module testbench;
  import ckpb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic               we;
    addr_t              addr;
    logic [COLOR_W-1:0] data;
    logic               last;
  } dest_write_t;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ckpb_pix_if pix_if ();
  ckpb_wr_if  wr_if ();

  color_keyed_palette_blit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .wr_o       (wr_if)
  );

  // register copies and rectangle walk of the model
  logic [PIXEL_W-1:0]    blit_key    = '0;
  logic [PAL_WORD_W-1:0] blit_pal_lo = '0;
  logic [PAL_WORD_W-1:0] blit_pal_hi = '0;
  dim_t                  blit_width  = 16'd1;
  dim_t                  blit_height = 16'd1;
  addr_t                 blit_base   = '0;
  dim_t                  blit_stride = 16'd1;
  dim_t                  col_pos     = '0;
  dim_t                  row_pos     = '0;
  addr_t                 row_addr    = '0;

  dest_write_t pending_writes[$];
  dest_write_t due_write;
  int          mismatches    = 0;
  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          sink_hold     = 0;

  always #2 clk_i = ~clk_i;

  function automatic dest_write_t blit_pixel(input logic [PIXEL_W-1:0] px);
    dest_write_t           w;
    dim_t                  last_col;
    dim_t                  last_row;
    logic [PAL_WORD_W-1:0] pal_word;
    logic                  row_end;
    last_col = blit_width - 16'd1;
    last_row = blit_height - 16'd1;
    if (col_pos == '0 && row_pos == '0) begin
      row_addr = blit_base;
    end
    w.addr   = row_addr + addr_t'(col_pos);
    w.we     = (px != blit_key);
    pal_word = px[3] ? blit_pal_hi : blit_pal_lo;
    w.data   = w.we ? pal_word[{px[2:0], 3'b000} +: 8] : '0;
    row_end  = (col_pos >= last_col);
    w.last   = row_end && (row_pos >= last_row);
    if (!row_end) begin
      col_pos = col_pos + 16'd1;
    end else begin
      col_pos = '0;
      if (w.last) begin
        row_pos  = '0;
        row_addr = blit_base;
      end else begin
        row_pos  = row_pos + 16'd1;
        row_addr = row_addr + addr_t'(blit_stride);
      end
    end
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    return ($urandom_range(4) == 0) ? blit_key : PIXEL_W'($urandom_range(255));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    case (idx)
      REG_KEY_COLOR:    blit_key    = v[PIXEL_W-1:0];
      REG_PALETTE_LOW:  blit_pal_lo = v;
      REG_PALETTE_HIGH: blit_pal_hi = v;
      REG_AREA_WIDTH:   blit_width  = v[DIM_W-1:0];
      REG_AREA_HEIGHT:  blit_height = v[DIM_W-1:0];
      REG_DEST_BASE:    blit_base   = v[BASE_W-1:0];
      REG_DEST_STRIDE:  blit_stride = v[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid        <= 1'b1;
    pix_if.source_pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    pending_writes.push_back(blit_pixel(px));
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    @(posedge clk_i);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    @(negedge clk_i);
  endtask

  task automatic randomize_registers();
    logic [CFG_DATA_W-1:0] v;
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(7))
        0: v[7:0] = 8'h00;
        1: v[7:0] = 8'hff;
        default: ;
      endcase
      write_reg(REG_KEY_COLOR, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(7))
        0: v = '0;
        1: v = '1;
        default: ;
      endcase
      write_reg(REG_PALETTE_LOW, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(7))
        0: v = '0;
        1: v = '1;
        default: ;
      endcase
      write_reg(REG_PALETTE_HIGH, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(19))
        0: v[15:0] = 16'hffff;
        1: v[15:0] = 16'h0000;
        default: v[15:0] = 16'($urandom_range(1, 8));
      endcase
      write_reg(REG_AREA_WIDTH, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(19))
        0: v[15:0] = 16'hffff;
        1: v[15:0] = 16'h0000;
        default: v[15:0] = 16'($urandom_range(1, 6));
      endcase
      write_reg(REG_AREA_HEIGHT, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(7))
        0: v[23:0] = 24'h000000;
        1: v[23:0] = 24'hffffff;
        default: ;
      endcase
      write_reg(REG_DEST_BASE, v);
    end
    if ($urandom_range(1)) begin
      v = rand_word();
      case ($urandom_range(7))
        0: v[15:0] = 16'h0000;
        1: v[15:0] = 16'hffff;
        2, 3: ;
        default: v[15:0] = 16'($urandom_range(1, 40));
      endcase
      write_reg(REG_DEST_STRIDE, v);
    end
  endtask

  task automatic test_reset_state();
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h5a);
  endtask

  task automatic test_unknown_index();
    drain();
    write_reg(REG_UNUSED, '1);
    send_pixel(8'h00);
    send_pixel(8'h01);
  endtask

  // all sixteen low nibbles, key in the middle, address wraps past the top
  task automatic test_palette_and_key();
    drain();
    write_reg(REG_KEY_COLOR, 64'h77);
    write_reg(REG_PALETTE_LOW, 64'h8e71_d42b_f036_a95c);
    write_reg(REG_PALETTE_HIGH, 64'hff00_5aa5_3cc3_0ff0);
    write_reg(REG_AREA_WIDTH, 64'd4);
    write_reg(REG_AREA_HEIGHT, 64'd4);
    write_reg(REG_DEST_BASE, 64'hff_fffa);
    write_reg(REG_DEST_STRIDE, 64'hffff);
    for (int i = 0; i < 16; i++) send_pixel({4'(i), 4'(i)});
  endtask

  task automatic test_zero_stride();
    drain();
    write_reg(REG_AREA_WIDTH, 64'd2);
    write_reg(REG_AREA_HEIGHT, 64'd2);
    write_reg(REG_DEST_BASE, 64'h12_3456);
    write_reg(REG_DEST_STRIDE, 64'd0);
    send_pixel(8'h77);
    send_pixel(8'h0f);
    send_pixel(8'hf0);
    send_pixel(8'h81);
  endtask

  // zero size acts as full range, then the rectangle shrinks under the counters
  task automatic test_zero_size_and_shrink();
    drain();
    write_reg(REG_AREA_WIDTH, 64'd0);
    write_reg(REG_AREA_HEIGHT, 64'd0);
    write_reg(REG_DEST_STRIDE, 64'd5);
    repeat (3) send_pixel(pick_pixel());
    drain();
    write_reg(REG_AREA_WIDTH, 64'd2);
    write_reg(REG_AREA_HEIGHT, 64'd2);
    repeat (3) send_pixel(pick_pixel());
  endtask

  task automatic test_output_stall();
    drain();
    @(posedge clk_i);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    sink_hold     = 150;
    @(negedge clk_i);
    repeat (40) send_pixel(pick_pixel());
    drain();
  endtask

  task automatic test_random_blits(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      drain();
      randomize_registers();
      burst = $urandom_range(1, 60);
      repeat (burst) send_pixel(pick_pixel());
      sent += burst;
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold   <= sink_hold - 1;
      wr_if.ready <= 1'b0;
    end else begin
      wr_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        $error("write word with none expected");
        mismatches++;
      end else begin
        due_write = pending_writes.pop_front();
        if (wr_if.write_enable !== due_write.we) begin
          $error("write_enable expected %0d got %0d", due_write.we, wr_if.write_enable);
          mismatches++;
        end
        if (wr_if.dest_address !== due_write.addr) begin
          $error("dest_address expected %06h got %06h", due_write.addr, wr_if.dest_address);
          mismatches++;
        end
        if (wr_if.write_data !== due_write.data) begin
          $error("write_data expected %02h got %02h", due_write.data, wr_if.write_data);
          mismatches++;
        end
        if (wr_if.last !== due_write.last) begin
          $error("last expected %0d got %0d", due_write.last, wr_if.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pix_if.valid        = 1'b0;
    pix_if.source_pixel = '0;
    wr_if.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_unknown_index();
    test_palette_and_key();
    test_zero_stride();
    test_zero_size_and_shrink();
    drain();
    set_idling(36, 66);
    test_random_blits(355);
    set_idling(66, 36);
    test_random_blits(355);
    test_output_stall();
    set_idling(0, 0);
    test_random_blits(310);
    drain();
    repeat (6) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ckpb_pkg.sv
rtl/ckpb_if.sv
rtl/ckpb_cfg.sv
rtl/ckpb_front.sv
rtl/ckpb_queue.sv
rtl/ckpb_back.sv
rtl/color_keyed_palette_blit.sv
bench/testbench.sv
